/* rtl/core/asl_pkg.sv */
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the ADC sensor scan linearizer
// Action and sensor codes, register indexes, reset words, the conversion
// coefficients and the queue entry type.
// ----------------------------------------------------------------------------
package asl_pkg;

  // Result action codes
  localparam logic [1:0] ACT_IDLE = 2'd0;
  localparam logic [1:0] ACT_MUX  = 2'd1;
  localparam logic [1:0] ACT_CONV = 2'd2;

  // Sensor channel ids
  localparam logic [1:0] SID_FPA     = 2'd0;
  localparam logic [1:0] SID_LENS    = 2'd1;
  localparam logic [1:0] SID_SHUTTER = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_FPA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_LENS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_SHUTTER = 2'd2;

  localparam logic [15:0] MUX_FPA_RESET     = 16'hE383;
  localparam logic [15:0] MUX_LENS_RESET    = 16'hC383;
  localparam logic [15:0] MUX_SHUTTER_RESET = 16'hD383;

  // Scan sequence positions
  localparam logic [2:0] STEP_LAST        = 3'd7;
  localparam logic [2:0] STEP_MUX_FPA     = 3'd1;
  localparam logic [2:0] STEP_CONV_FPA    = 3'd2;
  localparam logic [2:0] STEP_MUX_LENS    = 3'd3;
  localparam logic [2:0] STEP_CONV_LENS   = 3'd4;
  localparam logic [2:0] STEP_MUX_SHUTTER = 3'd5;
  localparam logic [2:0] STEP_CONV_SHUTTER = 3'd6;

  // Shared multiplier: 17-bit signed (zero-extended code) by MUL_W signed
  localparam int unsigned MUL_W  = 26;
  localparam int unsigned PROD_W = MUL_W + 17;
  localparam int unsigned LO_W   = 24;

  // FPA: T = (NUM - SLOPE*a) / 10^7
  localparam logic signed [63:0]      FPA_NUM   = 64'sd338180000000;
  localparam logic signed [MUL_W-1:0] FPA_SLOPE = 26'sd18181804;

  // Cubic: N = C0 + a*(a*(C2 - C3*a) - C1), T = N / 10^13
  localparam logic signed [63:0]      CUB_C0  = 64'sd127361304901973000;
  localparam logic signed [63:0]      CUB_C1  = 64'sd18218076216914;
  localparam logic signed [63:0]      CUB_C2  = 64'sd1218402729;
  localparam logic signed [MUL_W-1:0] CUB_C3  = 26'sd40235;

  // Multiply sequence: last step index per conversion kind
  localparam logic [2:0] MSTEP_FPA_LAST = 3'd0;
  localparam logic [2:0] MSTEP_CUB_LAST = 3'd4;

  // Divide by 10^k: shift out 2^k, then divide by 5^k with a reciprocal
  // estimate that is low by at most one, fixed by one compare and subtract
  localparam int unsigned QUOT_BITS  = 17;
  localparam int unsigned FPA_DIV_SH = 7;
  localparam int unsigned CUB_DIV_SH = 13;
  localparam int unsigned CUB_PRE_SH = 14;
  localparam logic [31:0] FPA_DIV5   = 32'd78125;
  localparam logic [31:0] CUB_DIV5   = 32'd1220703125;
  // floor(2^32 / 5^7) and floor(2^46 / 5^13)
  localparam logic [15:0] FPA_RECIP  = 16'd54975;
  localparam logic [15:0] CUB_RECIP  = 16'd57646;
  // 32769 * 5^k: at or above this the quotient saturates either way
  localparam logic [63:0] FPA_SAT_LIM = 64'd2560078125;
  localparam logic [63:0] CUB_SAT_LIM = 64'd40001220703125;
  localparam logic [QUOT_BITS-1:0] QUOT_SAT = 17'd32769;

  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Entry of the queue between front and back
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  sid;
    logic [15:0] word;
    logic [15:0] adc;
  } asl_cmd_t;

endpackage

/* rtl/core/asl_in_if.sv */
// ----------------------------------------------------------------------------
// asl_in_if: sample channel
// Valid/ready channel carrying one ADC code per tick.
// ----------------------------------------------------------------------------
interface asl_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

/* rtl/core/asl_out_if.sv */
// ----------------------------------------------------------------------------
// asl_out_if: result channel
// Valid/ready channel carrying one result per tick.
// ----------------------------------------------------------------------------
interface asl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         step_action;
  logic [15:0]        mux_word_out;
  logic [1:0]         sensor_id;
  logic signed [15:0] new_temp;
  logic signed [15:0] fpa_temp;
  logic signed [15:0] lens_temp;
  logic signed [15:0] shutter_temp;

  modport source (output valid, output step_action, output mux_word_out,
                  output sensor_id, output new_temp, output fpa_temp,
                  output lens_temp, output shutter_temp, input ready);
  modport sink   (input valid, input step_action, input mux_word_out,
                  input sensor_id, input new_temp, input fpa_temp,
                  input lens_temp, input shutter_temp, output ready);
endinterface

/* rtl/core/asl_cfg_if.sv */
// ----------------------------------------------------------------------------
// asl_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface asl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/asl_front.sv */
// ----------------------------------------------------------------------------
// asl_front: scan sequencer front end
// Holds the mux word registers and the step counter, accepts samples and
// classifies each one into a command for the back end queue.
// ----------------------------------------------------------------------------
module asl_front
  import asl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  asl_in_if.sink    sample,
  asl_cfg_if.sink   cfg,
  input  logic      full,
  output logic      push,
  output asl_cmd_t  cmd
);

  logic [15:0] mux_fpa;
  logic [15:0] mux_lens;
  logic [15:0] mux_shutter;
  logic [2:0]  step;
  logic [2:0]  step_next;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !full;
  assign push         = sample.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_fpa     <= MUX_FPA_RESET;
      mux_lens    <= MUX_LENS_RESET;
      mux_shutter <= MUX_SHUTTER_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MUX_FPA:     mux_fpa     <= cfg.data;
        REG_MUX_LENS:    mux_lens    <= cfg.data;
        REG_MUX_SHUTTER: mux_shutter <= cfg.data;
        default: ;
      endcase
    end
  end

  assign step_next = (step == STEP_LAST) ? 3'd0 : step + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (push) begin
      step <= step_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.adc    = sample.adc_code;
    cmd.action = ACT_IDLE;
    cmd.sid    = SID_FPA;
    cmd.word   = 16'd0;
    case (step_next)
      STEP_MUX_FPA: begin
        cmd.action = ACT_MUX;
        cmd.word   = mux_fpa;
      end
      STEP_CONV_FPA: begin
        cmd.action = ACT_CONV;
      end
      STEP_MUX_LENS: begin
        cmd.action = ACT_MUX;
        cmd.sid    = SID_LENS;
        cmd.word   = mux_lens;
      end
      STEP_CONV_LENS: begin
        cmd.action = ACT_CONV;
        cmd.sid    = SID_LENS;
      end
      STEP_MUX_SHUTTER: begin
        cmd.action = ACT_MUX;
        cmd.sid    = SID_SHUTTER;
        cmd.word   = mux_shutter;
      end
      STEP_CONV_SHUTTER: begin
        cmd.action = ACT_CONV;
        cmd.sid    = SID_SHUTTER;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/asl_queue.sv */
// ----------------------------------------------------------------------------
// asl_queue: command queue between front and back end
// Small FIFO of classified commands; lets either side stall on its own.
// ----------------------------------------------------------------------------
module asl_queue
  import asl_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  asl_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output asl_cmd_t head,
  output logic     head_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  asl_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH))
    else $error("queue pushed while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* rtl/core/asl_back.sv */
// ----------------------------------------------------------------------------
// asl_back: conversion back end
// Executes queued commands: passes mux and idle steps to the result
// register, runs conversions on a shared multiplier and a reciprocal
// divide, and keeps the stored temperatures.
// ----------------------------------------------------------------------------
module asl_back
  import asl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  asl_cmd_t  head,
  input  logic      head_valid,
  output logic      pop,
  asl_out_if.source result
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ABS   = 7'b0000100,
    S_RECIP = 7'b0001000,
    S_BACK  = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_DONE  = 7'b1000000
  } bstate_t;

  bstate_t state;

  logic [15:0]            a;
  logic [1:0]             sid;
  logic                   is_cubic;
  logic [2:0]             mstep;
  logic signed [63:0]     n;
  logic signed [63:0]     part;
  logic [63:0]            rem;
  logic                   neg;
  logic [QUOT_BITS-1:0]   q;

  logic signed [MUL_W-1:0]  mul_x;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       prod64;
  logic signed [63:0]       prod_sh;
  logic [2:0]               mstep_last;
  logic [QUOT_BITS-1:0]     q_neg;
  logic signed [15:0]       temp;
  logic                     ofree;
  logic                     out_load;
  logic [63:0]              n_mag;
  logic [31:0]              div5;
  logic [63:0]              sat_lim;
  logic [31:0]              dm_a;
  logic [15:0]              dm_b;
  logic [47:0]              dm_p;

  logic signed [15:0] fpa_store;
  logic signed [15:0] lens_store;
  logic signed [15:0] shutter_store;

  assign ofree      = !result.valid || result.ready;
  assign mstep_last = is_cubic ? MSTEP_CUB_LAST : MSTEP_FPA_LAST;

  // Pop mux and idle steps only when the result register is free;
  // conversions are pulled in right away.
  assign pop = (state == S_IDLE) && head_valid &&
               ((head.action == ACT_CONV) || ofree);

  assign out_load = (pop && (head.action != ACT_CONV)) || ((state == S_DONE) && ofree);

  always_comb begin
    case (mstep)
      3'd0:    mul_x = is_cubic ? CUB_C3 : FPA_SLOPE;
      3'd1:    mul_x = {2'b00, n[LO_W-1:0]};
      3'd2:    mul_x = {{(MUL_W-8){n[31]}}, n[31:LO_W]};
      3'd3:    mul_x = {2'b00, n[LO_W-1:0]};
      3'd4:    mul_x = {{(MUL_W-LO_W){n[47]}}, n[47:LO_W]};
      default: mul_x = '0;
    endcase
  end

  assign prod    = $signed({1'b0, a}) * mul_x;
  assign prod64  = {{(64-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_sh = {prod64[63-LO_W:0], {LO_W{1'b0}}};

  assign n_mag   = n[63] ? $unsigned(-n) : $unsigned(n);
  assign div5    = is_cubic ? CUB_DIV5 : FPA_DIV5;
  assign sat_lim = is_cubic ? CUB_SAT_LIM : FPA_SAT_LIM;

  // Divide multiplier: quotient estimate, then back-multiply of the estimate
  always_comb begin
    if (state == S_BACK) begin
      dm_a = div5;
      dm_b = q[15:0];
    end else begin
      dm_a = is_cubic ? rem[CUB_PRE_SH+31:CUB_PRE_SH] : rem[31:0];
      dm_b = is_cubic ? CUB_RECIP : FPA_RECIP;
    end
  end

  assign dm_p = dm_a * dm_b;

  // Apply sign and saturate the quotient magnitude
  assign q_neg = ~q + 1'b1;
  always_comb begin
    if (!neg) begin
      temp = (q > QUOT_BITS'(32767)) ? TEMP_MAX : $signed(q[15:0]);
    end else begin
      temp = (q > QUOT_BITS'(32768)) ? TEMP_MIN : $signed(q_neg[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result.valid  <= 1'b0;
      fpa_store     <= '0;
      lens_store    <= '0;
      shutter_store <= '0;
    end else begin
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.action == ACT_CONV) begin
              a        <= head.adc;
              sid      <= head.sid;
              is_cubic <= (head.sid != SID_FPA);
              mstep    <= 3'd0;
              state    <= S_MUL;
            end else begin
              result.step_action  <= head.action;
              result.mux_word_out <= head.word;
              result.sensor_id    <= head.sid;
              result.new_temp     <= '0;
            end
          end
        end
        S_MUL: begin
          if (!is_cubic) begin
            n <= FPA_NUM - prod64;
          end else begin
            case (mstep)
              3'd0:    n    <= CUB_C2 - prod64;
              3'd2:    n    <= prod_sh + part - CUB_C1;
              3'd4:    n    <= CUB_C0 + prod_sh + part;
              default: part <= prod64;
            endcase
          end
          if (mstep == mstep_last) begin
            state <= S_ABS;
          end else begin
            mstep <= mstep + 3'd1;
          end
        end
        S_ABS: begin
          neg   <= n[63];
          rem   <= is_cubic ? (n_mag >> CUB_DIV_SH) : (n_mag >> FPA_DIV_SH);
          state <= S_RECIP;
        end
        S_RECIP: begin
          // Out of range either way: skip the exact quotient
          if (rem >= sat_lim) begin
            q     <= QUOT_SAT;
            state <= S_DONE;
          end else begin
            q     <= {1'b0, dm_p[47:32]};
            state <= S_BACK;
          end
        end
        S_BACK: begin
          rem   <= rem - {16'd0, dm_p};
          state <= S_FIX;
        end
        S_FIX: begin
          // Estimate runs low by at most one
          if (rem >= {32'd0, div5}) begin
            q <= q + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the result register frees up
          if (ofree) begin
            case (sid)
              SID_FPA:     fpa_store     <= temp;
              SID_LENS:    lens_store    <= temp;
              default:     shutter_store <= temp;
            endcase
            result.step_action  <= ACT_CONV;
            result.mux_word_out <= '0;
            result.sensor_id    <= sid;
            result.new_temp     <= temp;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.fpa_temp     = fpa_store;
  assign result.lens_temp    = lens_store;
  assign result.shutter_temp = shutter_store;

`ifndef ASSERT_OFF
  a_fpa_stored: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_action == ACT_CONV && result.sensor_id == SID_FPA
    |-> result.fpa_temp == result.new_temp)
    else $error("FPA store differs from converted value");

  a_lens_stored: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_action == ACT_CONV && result.sensor_id == SID_LENS
    |-> result.lens_temp == result.new_temp)
    else $error("lens store differs from converted value");

  a_shutter_stored: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_action == ACT_CONV &&
    result.sensor_id == SID_SHUTTER
    |-> result.shutter_temp == result.new_temp)
    else $error("shutter store differs from converted value");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_action == ACT_IDLE
    |-> result.mux_word_out == '0 && result.new_temp == '0 &&
        result.sensor_id == SID_FPA)
    else $error("idle result carries nonzero fields");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !pop)
    else $error("command popped during a conversion");
`endif

endmodule

/* rtl/core/adc_sensor_scan_linearizer_unit.sv */
// ----------------------------------------------------------------------------
// adc_sensor_scan_linearizer_unit: ADC sensor scan and linearizer
// Steps through the FPA, lens NTC and shutter channels, issues mux words and
// converts ADC codes to saturated 16-bit temperatures.
//
//   channel  dir  transfer carries
//   sample   in   adc_code
//   result   out  step_action, mux_word_out, sensor_id, new_temp,
//                 fpa_temp, lens_temp, shutter_temp
//   cfg      in   index, data (mux word registers 0..2)
//
// Mux and idle steps are popped from the queue head once the result register
// is free and go straight into it. A conversion runs the shared multiplier
// steps (1 for FPA, 5 for lens or shutter), then magnitude and shift,
// reciprocal estimate, back-multiply, correction and retire; an out-of-range
// quotient skips back-multiply and correction. A stalled result holds the
// back end; the front keeps taking samples while the queue has room. Reset
// is synchronous and returns step counter, stores and mux words to defaults.
// ----------------------------------------------------------------------------
module adc_sensor_scan_linearizer_unit
  import asl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  logic      clk,
  input  logic      rst,
  asl_in_if.sink    sample,
  asl_out_if.source result,
  asl_cfg_if.sink   cfg
);

  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;
  asl_cmd_t cmd;
  asl_cmd_t head;

  asl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .cmd    (cmd)
  );

  asl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  asl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

/* tb/sv/adc_sensor_scan_linearizer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_sensor_scan_linearizer_unit_test: self-checking bench of the scan unit
// Drives ADC codes through the sample channel and mux words through the cfg
// channel, predicts every result of the eight-step scan cycle (mux words,
// FPA linear and NTC cubic conversions with saturation, stored temperatures)
// and compares each result transfer field by field, under random idling.
// ----------------------------------------------------------------------------
module adc_sensor_scan_linearizer_unit_test;
  import asl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Scaled integer coefficients of the two conversion curves
  localparam longint LIN_OFFSET  = 64'sd338180000000;
  localparam longint LIN_SLOPE   = 64'sd18181804;
  localparam longint LIN_SCALE   = 64'sd10000000;
  localparam longint POLY_K0     = 64'sd127361304901973000;
  localparam longint POLY_K1     = 64'sd18218076216914;
  localparam longint POLY_K2     = 64'sd1218402729;
  localparam longint POLY_K3     = 64'sd40235;
  localparam longint POLY_SCALE  = 64'sd10000000000000;

  typedef struct {
    logic [1:0]         action;
    logic [15:0]        word;
    logic [1:0]         sid;
    logic signed [15:0] temp_now;
    logic signed [15:0] temp_fpa;
    logic signed [15:0] temp_lens;
    logic signed [15:0] temp_shutter;
  } scan_result_t;

  logic clk;
  logic rst;

  asl_in_if  sample_if ();
  asl_out_if result_if ();
  asl_cfg_if cfg_if ();

  adc_sensor_scan_linearizer_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Predicted scan state and register copies
  logic [2:0]         scan_step;
  logic signed [15:0] fpa_hold;
  logic signed [15:0] lens_hold;
  logic signed [15:0] shutter_hold;
  logic [15:0]        word_fpa;
  logic [15:0]        word_lens;
  logic [15:0]        word_shutter;

  scan_result_t scan_results_due[$];
  int           mismatch_count;
  bit           gaps_on;
  bit           stalls_on;
  int           stall_left;

  always #5 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("FAIL adc_sensor_scan_linearizer_unit");
    $finish;
  end

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return TEMP_MAX;
    if (v < -32768) return TEMP_MIN;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] fpa_celsius(input logic [15:0] code);
    longint a;
    a = longint'(code);
    return clamp16((LIN_OFFSET - LIN_SLOPE * a) / LIN_SCALE);
  endfunction

  function automatic logic signed [15:0] ntc_celsius(input logic [15:0] code);
    longint a;
    longint acc;
    a = longint'(code);
    acc = POLY_K2 - POLY_K3 * a;
    acc = a * acc - POLY_K1;
    return clamp16((POLY_K0 + a * acc) / POLY_SCALE);
  endfunction

  // Advance the scan by one tick and return what the unit must emit
  function automatic scan_result_t predict_tick(input logic [15:0] code);
    scan_result_t r;
    r.action   = ACT_IDLE;
    r.word     = '0;
    r.sid      = SID_FPA;
    r.temp_now = '0;
    scan_step = (scan_step == STEP_LAST) ? 3'd0 : scan_step + 3'd1;
    case (scan_step)
      STEP_MUX_FPA: begin
        r.action = ACT_MUX;
        r.word   = word_fpa;
      end
      STEP_CONV_FPA: begin
        r.action   = ACT_CONV;
        r.temp_now = fpa_celsius(code);
        fpa_hold   = r.temp_now;
      end
      STEP_MUX_LENS: begin
        r.action = ACT_MUX;
        r.word   = word_lens;
        r.sid    = SID_LENS;
      end
      STEP_CONV_LENS: begin
        r.action   = ACT_CONV;
        r.sid      = SID_LENS;
        r.temp_now = ntc_celsius(code);
        lens_hold  = r.temp_now;
      end
      STEP_MUX_SHUTTER: begin
        r.action = ACT_MUX;
        r.word   = word_shutter;
        r.sid    = SID_SHUTTER;
      end
      STEP_CONV_SHUTTER: begin
        r.action     = ACT_CONV;
        r.sid        = SID_SHUTTER;
        r.temp_now   = ntc_celsius(code);
        shutter_hold = r.temp_now;
      end
      default: ;
    endcase
    r.temp_fpa     = fpa_hold;
    r.temp_lens    = lens_hold;
    r.temp_shutter = shutter_hold;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Predict on sample transfers, track register writes, check result transfers
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      scan_step    = '0;
      fpa_hold     = '0;
      lens_hold    = '0;
      shutter_hold = '0;
      word_fpa     = MUX_FPA_RESET;
      word_lens    = MUX_LENS_RESET;
      word_shutter = MUX_SHUTTER_RESET;
      scan_results_due.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_MUX_FPA:     word_fpa = cfg_if.data;
          REG_MUX_LENS:    word_lens = cfg_if.data;
          REG_MUX_SHUTTER: word_shutter = cfg_if.data;
          default: ;
        endcase
      end
      if (sample_if.valid && sample_if.ready)
        scan_results_due.push_back(predict_tick(sample_if.adc_code));
      if (result_if.valid && result_if.ready) begin
        if (scan_results_due.size() == 0) begin
          report_mismatch("result with nothing due, action", result_if.step_action, 0);
        end else begin
          want = scan_results_due.pop_front();
          if (result_if.step_action !== want.action)
            report_mismatch("step_action", result_if.step_action, want.action);
          if (result_if.mux_word_out !== want.word)
            report_mismatch("mux_word_out", result_if.mux_word_out, want.word);
          if (result_if.sensor_id !== want.sid)
            report_mismatch("sensor_id", result_if.sensor_id, want.sid);
          if (result_if.new_temp !== want.temp_now)
            report_mismatch("new_temp", result_if.new_temp, want.temp_now);
          if (result_if.fpa_temp !== want.temp_fpa)
            report_mismatch("fpa_temp", result_if.fpa_temp, want.temp_fpa);
          if (result_if.lens_temp !== want.temp_lens)
            report_mismatch("lens_temp", result_if.lens_temp, want.temp_lens);
          if (result_if.shutter_temp !== want.temp_shutter)
            report_mismatch("shutter_temp", result_if.shutter_temp, want.temp_shutter);
        end
      end
    end
  end

  // Result back pressure: drop ready in bursts of random length while stalls are on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_if.ready = 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      result_if.ready = 1'b0;
    end else begin
      result_if.ready = 1'b1;
    end
  end

  // Present one code and hold it until the transfer; valid stays high after
  task automatic send_code(input logic [15:0] code);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_if.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample_if.adc_code = code;
    sample_if.valid    = 1'b1;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_if.index = idx;
    cfg_if.data  = value;
    cfg_if.valid = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Hold the sender until every due result has arrived, then let the back end settle
  task automatic drain_results();
    sample_if.valid = 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Codes weighted toward the saturation and zero-crossing regions
  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(400, 800));
      3: return 16'($urandom_range(18400, 18800));
      4: return 16'($urandom_range(36000, 37200));
      5: return 16'($urandom_range(26000, 30000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Three full scan cycles at reset mux words, codes at both ends and near edges
  task automatic test_edge_codes();
    logic [15:0] codes [24];
    codes = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h1234, 16'hFFFF,
              16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555,
              16'h5555, 16'd18600, 16'h0001, 16'd578, 16'h8000, 16'd36622, 16'h7FFF, 16'h0000};
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    foreach (codes[i]) send_code(codes[i]);
    drain_results();
  endtask

  // Write every mux word, extremes included, plus the unused index
  task automatic test_mux_words();
    write_reg(REG_MUX_FPA, 16'h0000);
    write_reg(REG_MUX_LENS, 16'hFFFF);
    write_reg(REG_MUX_SHUTTER, 16'h5A5A);
    write_reg(REG_UNUSED, 16'h1234);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (8) send_code(pick_code());
    drain_results();
    write_reg(REG_MUX_FPA, 16'hFFFF);
    write_reg(REG_MUX_LENS, 16'h0000);
    write_reg(REG_MUX_SHUTTER, 16'hA5A5);
    write_reg(REG_UNUSED, 16'hFFFF);
    repeat (8) send_code(pick_code());
    drain_results();
  endtask

  // Random codes, idling switched on and off in stretches
  task automatic test_random_scan(input int count);
    write_reg(REG_MUX_FPA, 16'($urandom_range(0, 65535)));
    write_reg(REG_MUX_LENS, 16'($urandom_range(0, 65535)));
    write_reg(REG_MUX_SHUTTER, 16'($urandom_range(0, 65535)));
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        gaps_on   = 1'($urandom_range(0, 1));
        stalls_on = 1'($urandom_range(0, 1));
      end
      send_code(pick_code());
    end
    drain_results();
  endtask

  // Pause the sender mid-cycle until all results are back, then resume
  task automatic test_sender_pause();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (21) send_code(pick_code());
    drain_results();
    repeat (27) send_code(pick_code());
    drain_results();
  endtask

  // Back-to-back stream with no idling on either side
  task automatic test_steady_stream(input int count);
    write_reg(REG_MUX_FPA, 16'($urandom_range(0, 65535)));
    write_reg(REG_MUX_SHUTTER, 16'($urandom_range(0, 65535)));
    gaps_on    = 1'b0;
    stalls_on  = 1'b0;
    repeat (count) send_code(pick_code());
    drain_results();
  endtask

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    sample_if.valid    = 1'b0;
    sample_if.adc_code = '0;
    result_if.ready    = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    mismatch_count     = 0;
    gaps_on            = 1'b0;
    stalls_on          = 1'b0;
    stall_left         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    test_edge_codes();
    test_mux_words();
    test_random_scan(300);
    test_sender_pause();
    test_random_scan(260);
    test_steady_stream(400);

    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS adc_sensor_scan_linearizer_unit");
    end else begin
      $display("FAIL adc_sensor_scan_linearizer_unit");
    end
    $finish;
  end

endmodule
